// ----- hdl/mbom_pkg.sv -----
// Shared types and constants for the buffer ownership manager.
package mbom_pkg;

    localparam int POOL_MAX      = 32;
    localparam int ID_W          = 5;
    localparam int OP_W          = 2;
    localparam int NUM_W         = 6;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 8;
    localparam logic [NUM_W-1:0] NUM_RESET = 6'd32;

    typedef enum logic [OP_W-1:0] {
        OP_WR_ACQ  = 2'd0,
        OP_RD_ACQ  = 2'd1,
        OP_WR_DONE = 2'd2,
        OP_RD_DONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_WRITING = 2'd1,
        ST_WRITTEN = 2'd2,
        ST_READING = 2'd3
    } buf_status_t;

    typedef struct packed {
        logic [ID_W-1:0] buffer_id;
        op_t             op;
    } mbom_req_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            found;
    } mbom_res_t;

endpackage

// ----- hdl/mbom_prio.sv -----
// Lowest-index priority encoder over a request vector.
module mbom_prio
    import mbom_pkg::*;
#(
    parameter int WIDTH = POOL_MAX
) (
    input  logic [WIDTH-1:0] req,
    output logic             found,
    output logic [ID_W-1:0]  idx
);

    always_comb begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (req[i]) begin
                idx = ID_W'(i);
            end
        end
    end

    assign found = |req;

endmodule

// ----- hdl/mbom_core.sv -----
// Pool state (in-use mask, per-buffer status) and the per-transaction update.
module mbom_core
    import mbom_pkg::*;
#(
    parameter int MAX_BUFFERS = POOL_MAX
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  mbom_req_t        req,
    input  logic [NUM_W-1:0] num_buffers,
    output mbom_res_t        res
);

    localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_BUFFERS);

    logic [MAX_BUFFERS-1:0] in_use_reg;
    buf_status_t            status_reg [MAX_BUFFERS];

    logic [NUM_W-1:0]       active_n;
    logic [MAX_BUFFERS-1:0] wr_req;
    logic [MAX_BUFFERS-1:0] rd_req;
    logic                   wr_found;
    logic                   rd_found;
    logic [ID_W-1:0]        wr_idx;
    logic [ID_W-1:0]        rd_idx;
    logic                   id_ok;

    assign active_n = (num_buffers > MAX_N) ? MAX_N : num_buffers;
    assign id_ok    = {1'b0, req.buffer_id} < MAX_N;

    always_comb begin
        for (int i = 0; i < MAX_BUFFERS; i++) begin
            wr_req[i] = !in_use_reg[i] && (NUM_W'(i) < active_n);
            rd_req[i] = in_use_reg[i] && (status_reg[i] == ST_WRITTEN)
                        && (NUM_W'(i) < active_n);
        end
    end

    mbom_prio #(.WIDTH(MAX_BUFFERS)) u_wr_prio (
        .req   (wr_req),
        .found (wr_found),
        .idx   (wr_idx)
    );

    mbom_prio #(.WIDTH(MAX_BUFFERS)) u_rd_prio (
        .req   (rd_req),
        .found (rd_found),
        .idx   (rd_idx)
    );

    always_comb begin
        res = '0;
        case (req.op)
            OP_WR_ACQ: begin
                res.found      = wr_found;
                res.granted_id = wr_idx;
            end
            OP_RD_ACQ: begin
                res.found      = rd_found;
                res.granted_id = rd_idx;
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            for (int i = 0; i < MAX_BUFFERS; i++) begin
                status_reg[i] <= ST_IDLE;
            end
        end else if (fire) begin
            for (int i = 0; i < MAX_BUFFERS; i++) begin
                case (req.op)
                    OP_WR_ACQ: begin
                        if (wr_found && wr_idx == ID_W'(i)) begin
                            in_use_reg[i] <= 1'b1;
                            status_reg[i] <= ST_WRITING;
                        end
                    end
                    OP_RD_ACQ: begin
                        if (rd_found && rd_idx == ID_W'(i)) begin
                            status_reg[i] <= ST_READING;
                        end
                    end
                    OP_WR_DONE: begin
                        if (id_ok && req.buffer_id == ID_W'(i)) begin
                            status_reg[i] <= ST_WRITTEN;
                        end
                    end
                    OP_RD_DONE: begin
                        if (id_ok && req.buffer_id == ID_W'(i)) begin
                            status_reg[i] <= ST_IDLE;
                            in_use_reg[i] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- hdl/multi_buffer_ownership_manager.sv -----
// A transaction waits in the input register; its result goes to the result
// register behind m_tvalid. One transaction per cycle unless m_tready stalls:
// a single pass of priority encode and state update joins the two registers.
// Stalls on m_tready back up through the input register to s_tready.
// Reset (aresetn low, synchronous): all buffers idle and free,
// num_buffers back to 32, both registers empty.
module multi_buffer_ownership_manager
    import mbom_pkg::*;
#(
    parameter int MAX_BUFFERS = POOL_MAX
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [NUM_W-1:0]     cfg_wdata,     // num_buffers
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // op[1:0], buffer_id[6:2], pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // found[0], granted_id[5:1], pad
);

    logic [NUM_W-1:0] num_reg;
    logic             in_valid_reg;
    mbom_req_t        in_req_reg;
    logic             out_valid_reg;
    mbom_res_t        out_res_reg;
    mbom_res_t        core_res;
    logic             adv;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg       <= NUM_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                num_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= mbom_req_t'(s_tdata[ID_W+OP_W-1:0]);
        end
        if (adv) begin
            out_res_reg <= core_res;
        end
    end

    mbom_core #(.MAX_BUFFERS(MAX_BUFFERS)) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (adv),
        .req         (in_req_reg),
        .num_buffers (num_reg),
        .res         (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);

endmodule

// ----- hdl/mbom_checker.sv -----
// Port-level checker for the buffer ownership manager, bound to the top level.
module mbom_checker
    import mbom_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[ID_W:1] == '0)
        else $error("nonzero id without a grant");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:ID_W+1] == '0)
        else $error("result padding not zero");

endmodule

bind multi_buffer_ownership_manager mbom_checker u_mbom_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
